// ===== hdl/rrbc_pkg.sv =====
// Shared constants and types of the ROM/RAM bank controller.
package rrbc_pkg;

    localparam int unsigned ADDR_W        = 16;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ROM_BANK_W    = 7;
    localparam int unsigned RAM_BANK_W    = 8;
    localparam int unsigned ROM_COUNT_W   = 8;
    localparam int unsigned RAM_COUNT_W   = 3;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 8;

    localparam int unsigned MAX_ROM_BANKS = 128;
    localparam int unsigned MAX_RAM_BANKS = 4;

    // Width of the serial remainder units: dividends and divisors fit in one byte.
    localparam int unsigned MOD_W         = 8;
    localparam int unsigned MOD_STEPS     = MOD_W;
    localparam int unsigned MOD_CNT_W     = $clog2(MOD_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_COUNT = 1'b1;

    // Address regions inside 0x0000-0x7FFF, selected by address bits 14:13.
    localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REGION_ROM_LOW    = 2'd1;
    localparam logic [1:0] REGION_ROM_HIGH   = 2'd2;
    localparam logic [1:0] REGION_MODE       = 2'd3;

    localparam logic [3:0] RAM_ENABLE_KEY    = 4'hA;
    localparam logic [RAM_BANK_W-1:0] RAM_BANK_NONE = 8'hFF;

    typedef struct packed {
        logic load;
        logic shift;
    } mod_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== hdl/rrbc_if.sv =====
// Handshake interfaces of the bank controller: write requests, results, configuration.
interface rrbc_req_if;
    logic                               valid;
    logic                               ready;
    logic [rrbc_pkg::ADDR_W-1:0]        write_address;
    logic [rrbc_pkg::BYTE_W-1:0]        write_byte;

    modport source (output valid, output write_address, output write_byte, input ready);
    modport sink   (input valid, input write_address, input write_byte, output ready);
endinterface

interface rrbc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [rrbc_pkg::ROM_BANK_W-1:0]    fixed_bank;
    logic [rrbc_pkg::ROM_BANK_W-1:0]    switch_bank;
    logic                               ram_active;
    logic [rrbc_pkg::RAM_BANK_W-1:0]    ram_bank_out;

    modport source (output valid, output fixed_bank, output switch_bank,
                    output ram_active, output ram_bank_out, input ready);
    modport sink   (input valid, input fixed_bank, input switch_bank,
                    input ram_active, input ram_bank_out, output ready);
endinterface

interface rrbc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rrbc_pkg::CFG_INDEX_W-1:0]   index;
    logic [rrbc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rom_ram_bank_controller.sv =====
// Top level of the cartridge ROM/RAM bank controller in the MBC1 style.
//
//  Channel | Direction | Handshake     | Payload
//  --------+-----------+---------------+-------------------------------------------------
//  req     | in        | valid / ready | write_address[15:0], write_byte[7:0]
//  rsp     | out       | valid / ready | fixed_bank[6:0], switch_bank[6:0], ram_active,
//          |           |               | ram_bank_out[7:0]
//  cfg     | in        | valid / ready | index[0] (0 ROM bank count, 1 RAM bank count),
//          |           |               | data[7:0]
//
// A request passes through the accept cycle, a run state in which three bit-serial remainder
// units retire the dividend bits one by one, MSB first, and a commit cycle that loads the output
// register. Reset (rst_n, asynchronous, active low) sets ROM mode, RAM disabled, ROM bank 1,
// RAM bank 0, a ROM count of 2 and a RAM count of 0. A result may wait while the
// next request runs; a stall holds the block only in its commit cycle. The configuration port
// is always ready.
module rom_ram_bank_controller (
    input  logic          clk,
    input  logic          rst_n,
    rrbc_req_if.sink      req,
    rrbc_rsp_if.source    rsp,
    rrbc_cfg_if.sink      cfg
);

    // Configuration registers.
    logic [rrbc_pkg::ROM_COUNT_W-1:0] rom_count_reg;
    logic [rrbc_pkg::RAM_COUNT_W-1:0] ram_count_reg;

    // Banking state.
    logic                             mode_reg;
    logic                             ram_enable_reg;
    logic [rrbc_pkg::ROM_BANK_W-1:0]  rom_bank_reg;
    logic [rrbc_pkg::RAM_BANK_W-1:0]  ram_bank_reg;

    // Sequencer.
    rrbc_pkg::state_t                 state_reg;
    rrbc_pkg::state_t                 state_next;
    logic [rrbc_pkg::MOD_CNT_W-1:0]   cnt_reg;
    logic                             active_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [rrbc_pkg::ROM_BANK_W-1:0]  out_fixed_reg;
    logic [rrbc_pkg::ROM_BANK_W-1:0]  out_switch_reg;
    logic                             out_active_reg;
    logic [rrbc_pkg::RAM_BANK_W-1:0]  out_ram_reg;

    // Decode of the accepted request.
    logic                             accept;
    logic                             commit;
    logic [1:0]                       region;
    logic [4:0]                       low_bits;
    logic                             mode_new;
    logic                             enable_new;
    logic [rrbc_pkg::ROM_BANK_W-1:0]  rb_new;
    logic [rrbc_pkg::RAM_BANK_W-1:0]  xb_new;
    logic [rrbc_pkg::ROM_COUNT_W-1:0] rom_count_eff;
    logic [rrbc_pkg::RAM_COUNT_W-1:0] ram_count_eff;

    // Remainder unit operands and results.
    rrbc_pkg::mod_ctrl_t              mod_ctrl;
    logic [rrbc_pkg::MOD_W-1:0]       fixed_dividend;
    logic [rrbc_pkg::MOD_W-1:0]       switch_dividend;
    logic [rrbc_pkg::MOD_W-1:0]       ram_dividend;
    logic [rrbc_pkg::MOD_W-1:0]       rom_divisor;
    logic [rrbc_pkg::MOD_W-1:0]       ram_divisor;
    logic [rrbc_pkg::MOD_W-1:0]       fixed_rem;
    logic [rrbc_pkg::MOD_W-1:0]       switch_rem;
    logic [rrbc_pkg::MOD_W-1:0]       ram_rem;

    assign req.ready = (state_reg == rrbc_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    // The commit cycle loads the output register when it is empty or being drained.
    assign commit = (state_reg == rrbc_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    // A ROM count of zero or above the maximum means the maximum; the RAM count saturates.
    always_comb
    begin
        if (rom_count_reg == '0 || rom_count_reg > rrbc_pkg::ROM_COUNT_W'(rrbc_pkg::MAX_ROM_BANKS))
        begin
            rom_count_eff = rrbc_pkg::ROM_COUNT_W'(rrbc_pkg::MAX_ROM_BANKS);
        end
        else
        begin
            rom_count_eff = rom_count_reg;
        end
        if (ram_count_reg > rrbc_pkg::RAM_COUNT_W'(rrbc_pkg::MAX_RAM_BANKS))
        begin
            ram_count_eff = rrbc_pkg::RAM_COUNT_W'(rrbc_pkg::MAX_RAM_BANKS);
        end
        else
        begin
            ram_count_eff = ram_count_reg;
        end
    end

    // Register update of the request. Addresses at or above 0x8000 change nothing, but
    // the mode logic still runs and a result is still produced.
    always_comb
    begin
        region     = req.write_address[14:13];
        low_bits   = (req.write_byte[4:0] == 5'd0) ? 5'd1 : req.write_byte[4:0];
        mode_new   = mode_reg;
        enable_new = ram_enable_reg;
        rb_new     = rom_bank_reg;
        xb_new     = ram_bank_reg;
        if (!req.write_address[15])
        begin
            case (region)
                rrbc_pkg::REGION_RAM_ENABLE:
                begin
                    enable_new = (req.write_byte[3:0] == rrbc_pkg::RAM_ENABLE_KEY);
                end
                rrbc_pkg::REGION_ROM_LOW:
                begin
                    rb_new = {rom_bank_reg[6:5], low_bits};
                end
                rrbc_pkg::REGION_ROM_HIGH:
                begin
                    rb_new = {req.write_byte[1:0], rom_bank_reg[4:0]};
                    xb_new = req.write_byte;
                end
                rrbc_pkg::REGION_MODE:
                begin
                    mode_new = req.write_byte[0];
                end
                default:
                begin
                    mode_new = mode_reg;
                end
            endcase
        end
    end

    // In ROM mode the fixed window shows bank 0 and the RAM bank is forced to 0.
    // In RAM mode the upper ROM bits select the fixed bank and the switchable bank keeps
    // only its low five bits.
    always_comb
    begin
        if (mode_new)
        begin
            fixed_dividend  = {1'b0, rb_new[6:5], 5'd0};
            switch_dividend = {3'd0, rb_new[4:0]};
            ram_dividend    = xb_new;
        end
        else
        begin
            fixed_dividend  = '0;
            switch_dividend = {1'b0, rb_new};
            ram_dividend    = '0;
        end
        rom_divisor = rom_count_eff;
        // With no RAM the remainder is never used; divide by one to keep it defined.
        if (ram_count_eff == '0)
        begin
            ram_divisor = rrbc_pkg::MOD_W'(1);
        end
        else
        begin
            ram_divisor = {{(rrbc_pkg::MOD_W-rrbc_pkg::RAM_COUNT_W){1'b0}}, ram_count_eff};
        end
    end

    assign mod_ctrl.load  = accept;
    assign mod_ctrl.shift = (state_reg == rrbc_pkg::ST_RUN);

    rrbc_mod_serial u_fixed_mod (
        .clk       (clk),
        .ctrl      (mod_ctrl),
        .dividend  (fixed_dividend),
        .divisor   (rom_divisor),
        .remainder (fixed_rem)
    );

    rrbc_mod_serial u_switch_mod (
        .clk       (clk),
        .ctrl      (mod_ctrl),
        .dividend  (switch_dividend),
        .divisor   (rom_divisor),
        .remainder (switch_rem)
    );

    rrbc_mod_serial u_ram_mod (
        .clk       (clk),
        .ctrl      (mod_ctrl),
        .dividend  (ram_dividend),
        .divisor   (ram_divisor),
        .remainder (ram_rem)
    );

    // Sequencer: accept, run the remainder units for one step per dividend bit, commit.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rrbc_pkg::ST_RUN;
                end
            end
            rrbc_pkg::ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = rrbc_pkg::ST_DONE;
                end
            end
            rrbc_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    state_next = rrbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrbc_pkg::ST_IDLE;
            cnt_reg        <= '0;
            active_reg     <= 1'b0;
            rom_count_reg  <= rrbc_pkg::ROM_COUNT_W'(2);
            ram_count_reg  <= '0;
            mode_reg       <= 1'b0;
            ram_enable_reg <= 1'b0;
            rom_bank_reg   <= rrbc_pkg::ROM_BANK_W'(1);
            ram_bank_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    rrbc_pkg::CFG_ROM_COUNT:
                    begin
                        rom_count_reg <= cfg.data;
                    end
                    rrbc_pkg::CFG_RAM_COUNT:
                    begin
                        ram_count_reg <= cfg.data[rrbc_pkg::RAM_COUNT_W-1:0];
                    end
                    default:
                    begin
                        rom_count_reg <= rom_count_reg;
                    end
                endcase
            end

            if (accept)
            begin
                cnt_reg        <= rrbc_pkg::MOD_CNT_W'(rrbc_pkg::MOD_STEPS - 1);
                mode_reg       <= mode_new;
                ram_enable_reg <= enable_new;
                active_reg     <= enable_new && (ram_count_eff != '0);
            end
            else if (state_reg == rrbc_pkg::ST_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (commit)
            begin
                rom_bank_reg <= switch_rem[rrbc_pkg::ROM_BANK_W-1:0];
                ram_bank_reg <= active_reg ? ram_rem : rrbc_pkg::RAM_BANK_NONE;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; held while the result waits.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_fixed_reg  <= fixed_rem[rrbc_pkg::ROM_BANK_W-1:0];
            out_switch_reg <= switch_rem[rrbc_pkg::ROM_BANK_W-1:0];
            out_active_reg <= active_reg;
            out_ram_reg    <= active_reg ? ram_rem : rrbc_pkg::RAM_BANK_NONE;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.fixed_bank   = out_fixed_reg;
    assign rsp.switch_bank  = out_switch_reg;
    assign rsp.ram_active   = out_active_reg;
    assign rsp.ram_bank_out = out_ram_reg;

endmodule

// ===== hdl/rrbc_mod_serial.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle while shift is set, MSB first.
module rrbc_mod_serial (
    input  logic                         clk,
    input  rrbc_pkg::mod_ctrl_t          ctrl,
    input  logic [rrbc_pkg::MOD_W-1:0]   dividend,
    input  logic [rrbc_pkg::MOD_W-1:0]   divisor,
    output logic [rrbc_pkg::MOD_W-1:0]   remainder
);

    logic [rrbc_pkg::MOD_W-1:0] dividend_reg;
    logic [rrbc_pkg::MOD_W-1:0] dividend_next;
    logic [rrbc_pkg::MOD_W-1:0] divisor_reg;
    logic [rrbc_pkg::MOD_W-1:0] rem_reg;
    logic [rrbc_pkg::MOD_W-1:0] rem_next;
    logic [rrbc_pkg::MOD_W:0]   trial;

    // Shift the next dividend bit into the partial remainder and subtract when it fits.
    always_comb
    begin
        trial         = {rem_reg, dividend_reg[rrbc_pkg::MOD_W-1]};
        dividend_next = {dividend_reg[rrbc_pkg::MOD_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = rrbc_pkg::MOD_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = rrbc_pkg::MOD_W'(trial);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (ctrl.shift)
        begin
            dividend_reg <= dividend_next;
            rem_reg      <= rem_next;
        end
    end

    assign remainder = rem_reg;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the rom_ram_bank_controller bank-switching block.
module tb;

    import rrbc_pkg::*;

    // Banking mode as the mode register holds it: bit 0 of the byte written to 0x6000-0x7FFF.
    typedef enum logic {
        MODE_ROM = 1'b0,
        MODE_RAM = 1'b1
    } bank_mode_e;

    // One result of the block: the two ROM windows and the RAM selection.
    typedef struct packed {
        logic [ROM_BANK_W-1:0] fixed_bank;
        logic [ROM_BANK_W-1:0] switch_bank;
        logic                  ram_active;
        logic [RAM_BANK_W-1:0] ram_bank_out;
    } bank_view_t;

    // A row of the directed table is either a cartridge write or a new pair of bank counts.
    typedef enum logic {
        ROW_WRITE  = 1'b0,
        ROW_CONFIG = 1'b1
    } row_kind_e;

    // For a config row, data carries the ROM bank count and ram_count the RAM bank count.
    // A write row with typed set carries its expected result in want.
    typedef struct packed {
        row_kind_e              kind;
        logic [ADDR_W-1:0]      addr;
        logic [BYTE_W-1:0]      data;
        logic [RAM_COUNT_W-1:0] ram_count;
        logic                   typed;
        bank_view_t             want;
    } stim_row_t;

    localparam bank_view_t NO_VIEW = '0;

    // The directed part starts from the reset setting (2 ROM banks, no RAM), then walks the
    // counts through their extremes: a count of 0 and 255 for ROM, 5 and 7 for RAM, both of
    // which saturate. The early rows have results that follow by hand from the register
    // rules; later rows are left to the predictor.
    localparam int NUM_DIRECTED = 26;
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // Above 0x7FFF nothing changes, but a result still comes out.
        '{ROW_WRITE,  16'hFFFF, 8'hFF, 3'd0, 1'b1, '{7'd0,  7'd1,   1'b0, 8'hFF}},
        // RAM enabled, but no RAM banks are present, so RAM stays inactive.
        '{ROW_WRITE,  16'h0000, 8'h0A, 3'd0, 1'b1, '{7'd0,  7'd1,   1'b0, 8'hFF}},
        // A zero low ROM bank becomes bank 1.
        '{ROW_WRITE,  16'h2000, 8'h00, 3'd0, 1'b1, '{7'd0,  7'd1,   1'b0, 8'hFF}},
        // Bank 31 wraps to 1 with two ROM banks.
        '{ROW_WRITE,  16'h3FFF, 8'hFF, 3'd0, 1'b1, '{7'd0,  7'd1,   1'b0, 8'hFF}},
        '{ROW_CONFIG, 16'h0000, 8'd128, 3'd4, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h2000, 8'h1F, 3'd0, 1'b1, '{7'd0,  7'd31,  1'b1, 8'h00}},
        // ROM mode forces the RAM bank to 0 whatever was written.
        '{ROW_WRITE,  16'h4000, 8'hFF, 3'd0, 1'b1, '{7'd0,  7'd127, 1'b1, 8'h00}},
        // RAM mode moves the upper ROM bits to the fixed window and drops them.
        '{ROW_WRITE,  16'h6000, 8'h01, 3'd0, 1'b1, '{7'd96, 7'd31,  1'b1, 8'h00}},
        '{ROW_WRITE,  16'h5FFF, 8'h03, 3'd0, 1'b1, '{7'd96, 7'd31,  1'b1, 8'h03}},
        '{ROW_WRITE,  16'h7FFF, 8'hFE, 3'd0, 1'b1, '{7'd0,  7'd31,  1'b1, 8'h00}},
        '{ROW_WRITE,  16'h1FFF, 8'hFA, 3'd0, 1'b1, '{7'd0,  7'd31,  1'b1, 8'h00}},
        // A low nibble other than 0xA disables RAM.
        '{ROW_WRITE,  16'h0000, 8'hAB, 3'd0, 1'b1, '{7'd0,  7'd31,  1'b0, 8'hFF}},
        '{ROW_WRITE,  16'h8000, 8'h0A, 3'd0, 1'b1, '{7'd0,  7'd31,  1'b0, 8'hFF}},
        '{ROW_CONFIG, 16'h0000, 8'd255, 3'd7, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h0000, 8'h5A, 3'd0, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h6000, 8'hFF, 3'd0, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h4000, 8'h02, 3'd0, 1'b0, NO_VIEW},
        '{ROW_CONFIG, 16'h0000, 8'd0,   3'd3, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h4000, 8'hFF, 3'd0, 1'b0, NO_VIEW},
        '{ROW_CONFIG, 16'h0000, 8'd1,   3'd1, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h2000, 8'h05, 3'd0, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h4000, 8'h7F, 3'd0, 1'b0, NO_VIEW},
        '{ROW_CONFIG, 16'h0000, 8'd3,   3'd5, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h4000, 8'h03, 3'd0, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h2000, 8'h1E, 3'd0, 1'b0, NO_VIEW},
        '{ROW_WRITE,  16'h6000, 8'h00, 3'd0, 1'b0, NO_VIEW}
    };

    // The random part runs in phases; each phase starts from an idle block with new counts.
    // The first phases take fixed corner settings, the rest draw them at random.
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_CORNERS     = 8;
    localparam logic [ROM_COUNT_W-1:0] CORNER_ROM [NUM_CORNERS] =
        '{8'd0, 8'd1, 8'd128, 8'd255, 8'd2, 8'd3, 8'd127, 8'd64};
    localparam logic [RAM_COUNT_W-1:0] CORNER_RAM [NUM_CORNERS] =
        '{3'd0, 3'd1, 3'd4, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2};

    // Region edges, so that the decode boundaries are hit often.
    localparam logic [ADDR_W-1:0] REGION_EDGES [8] =
        '{16'h0000, 16'h1FFF, 16'h2000, 16'h3FFF, 16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF};

    // Cycles to wait after the last result for anything unexpected.
    localparam int SETTLE_CYCLES = 30;

    logic clk;
    logic rst_n;

    rrbc_req_if req_ch ();
    rrbc_rsp_if rsp_ch ();
    rrbc_cfg_if cfg_ch ();

    rom_ram_bank_controller i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state. It starts at the reset values, since reset is applied only once.
    logic [ROM_COUNT_W-1:0] rom_count_q = 8'd2;
    logic [RAM_COUNT_W-1:0] ram_count_q = 3'd0;
    bank_mode_e             mode_q      = MODE_ROM;
    logic                   ram_en_q    = 1'b0;
    logic [ROM_BANK_W-1:0]  rom_bank_q  = 7'd1;
    logic [RAM_BANK_W-1:0]  ram_bank_q  = 8'd0;

    // Results still owed by the block, oldest first.
    bank_view_t bank_views_due [$];
    int unsigned mismatch_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Nothing in a correct run comes close to this; a hang ends here.
    initial
    begin
        #10_000_000;
        $display("rom_ram_bank_controller test failed");
        $finish;
    end

    // Applies one cartridge write to the predictor state and returns the result it causes.
    function automatic bank_view_t predict_bank_write(input logic [ADDR_W-1:0] addr,
                                                      input logic [BYTE_W-1:0] data);
        logic [ROM_BANK_W-1:0] rb;
        logic [RAM_BANK_W-1:0] xb;
        logic [4:0]            low;
        int unsigned           romc;
        int unsigned           ramc;
        bank_view_t            view;

        rb   = rom_bank_q;
        xb   = ram_bank_q;
        romc = (rom_count_q == 0 || rom_count_q > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_count_q;
        ramc = (ram_count_q > MAX_RAM_BANKS) ? MAX_RAM_BANKS : ram_count_q;

        // Only the lower 32 KiB of the bus reaches the registers.
        if (!addr[15])
        begin
            case (addr[14:13])
                REGION_RAM_ENABLE: ram_en_q = (data[3:0] == RAM_ENABLE_KEY);
                REGION_ROM_LOW:
                begin
                    low = data[4:0];
                    if (low == 5'd0)
                        low = 5'd1;
                    rb = {rb[6:5], low};
                end
                REGION_ROM_HIGH:
                begin
                    rb = {data[1:0], rb[4:0]};
                    xb = data;
                end
                default: mode_q = data[0] ? MODE_RAM : MODE_ROM;
            endcase
        end

        if (mode_q == MODE_ROM)
        begin
            view.fixed_bank = '0;
            xb = '0;
        end
        else
        begin
            view.fixed_bank = ROM_BANK_W'({rb[6:5], 5'd0} % romc);
            rb = {2'b00, rb[4:0]};
        end

        rom_bank_q       = ROM_BANK_W'(rb % romc);
        view.switch_bank = rom_bank_q;
        view.ram_active  = ram_en_q && (ramc > 0);
        if (view.ram_active)
            ram_bank_q = RAM_BANK_W'(xb % ramc);
        else
            ram_bank_q = RAM_BANK_NONE;
        view.ram_bank_out = ram_bank_q;
        return view;
    endfunction

    // Idle length on either side: mostly none or short, now and then a long one.
    function automatic int unsigned random_pause();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offers one write request and returns at the edge where the block takes it.
    // The valid stays high so that a following request can go out back to back.
    task automatic issue_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
        req_ch.valid         <= 1'b1;
        req_ch.write_address <= addr;
        req_ch.write_byte    <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Holds the requests back until every owed result has come out; the block is then idle.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (bank_views_due.size() != 0)
            @(posedge clk);
    endtask

    // Writes both count registers back to back; only called while the block is idle.
    task automatic write_counts(input logic [ROM_COUNT_W-1:0] rom_count,
                                input logic [RAM_COUNT_W-1:0] ram_count);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ROM_COUNT;
        cfg_ch.data  <= CFG_DATA_W'(rom_count);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        rom_count_q = rom_count;
        cfg_ch.index <= CFG_RAM_COUNT;
        cfg_ch.data  <= CFG_DATA_W'(ram_count);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        ram_count_q = ram_count;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result side. The ready toggles between stretches of random length; a stall may land
    // on any cycle, including the one where a result has just been loaded. Every so often
    // a long stretch goes by with the ready held high.
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (1 + random_pause()) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Every result taken at an edge is checked against the oldest owed one. The values read
    // here are those from before the edge, so the order of processes within the step does
    // not matter.
    always @(posedge clk)
    begin
        bank_view_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (bank_views_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing owed: fixed %0d switch %0d active %0d ram %0d",
                         $time, rsp_ch.fixed_bank, rsp_ch.switch_bank, rsp_ch.ram_active,
                         rsp_ch.ram_bank_out);
            end
            else
            begin
                want = bank_views_due.pop_front();
                report_field("fixed_bank", 8'(want.fixed_bank), 8'(rsp_ch.fixed_bank));
                report_field("switch_bank", 8'(want.switch_bank), 8'(rsp_ch.switch_bank));
                report_field("ram_active", 8'(want.ram_active), 8'(rsp_ch.ram_active));
                report_field("ram_bank_out", want.ram_bank_out, rsp_ch.ram_bank_out);
            end
        end
    end

    // Request side: reset, the directed table, then the random phases.
    initial
    begin
        logic [ADDR_W-1:0]      addr;
        logic [BYTE_W-1:0]      data;
        logic [ROM_COUNT_W-1:0] rom_count;
        bank_view_t             view;
        int unsigned            gap;
        int unsigned            burst_left;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.write_address = '0;
        req_ch.write_byte    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_ROM_COUNT;
        cfg_ch.data          = '0;
        burst_left           = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].kind == ROW_CONFIG)
            begin
                wait_for_results();
                write_counts(DIRECTED[r].data, DIRECTED[r].ram_count);
            end
            else
            begin
                issue_write(DIRECTED[r].addr, DIRECTED[r].data);
                view = predict_bank_write(DIRECTED[r].addr, DIRECTED[r].data);
                bank_views_due.push_back(DIRECTED[r].typed ? DIRECTED[r].want : view);
                gap = random_pause();
                if (gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Each phase begins with the sender held off until the block has gone idle.
            wait_for_results();
            if (phase < NUM_CORNERS)
                write_counts(CORNER_ROM[phase], CORNER_RAM[phase]);
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    rom_count = ROM_COUNT_W'($urandom_range(1, MAX_ROM_BANKS));
                else
                    rom_count = ROM_COUNT_W'($urandom_range(0, 255));
                write_counts(rom_count, RAM_COUNT_W'($urandom_range(0, 7)));
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Spread the writes over the four register regions, their edges and the
                // addresses above them that change nothing.
                case ($urandom_range(0, 9))
                    0, 1:    addr = {3'b000, 13'($urandom)};
                    2, 3:    addr = {3'b001, 13'($urandom)};
                    4, 5:    addr = {3'b010, 13'($urandom)};
                    6, 7:    addr = {3'b011, 13'($urandom)};
                    8:       addr = REGION_EDGES[$urandom_range(0, 7)];
                    default: addr = {1'b1, 15'($urandom)};
                endcase
                data = BYTE_W'($urandom);

                // Half the RAM enable writes carry the key, and some low ROM bank writes
                // carry a zero bank number.
                if (!addr[15] && addr[14:13] == REGION_RAM_ENABLE && $urandom_range(0, 1) == 0)
                    data = {4'($urandom), RAM_ENABLE_KEY};
                if (!addr[15] && addr[14:13] == REGION_ROM_LOW && $urandom_range(0, 7) == 0)
                    data = {3'($urandom), 5'd0};

                issue_write(addr, data);
                bank_views_due.push_back(predict_bank_write(addr, data));

                if (burst_left != 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 199) == 0)
                        burst_left = $urandom_range(30, 80);
                    gap = random_pause();
                end

                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
                else if (gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        // Let the last results drain, then watch a little longer for stray ones.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && bank_views_due.size() == 0)
            $display("rom_ram_bank_controller test passed");
        else
            $display("rom_ram_bank_controller test failed");
        $finish;
    end

endmodule
